/* hw/rtl/efs_pkg.sv */
// Shared types, constants and scan helpers for the elevator target floor selector.
// No dependencies; every other file in hw/rtl imports this package.
`default_nettype none

package efs_pkg;

    // Building size and car position resolution
    localparam int NUM_FLOORS = 8;
    localparam int FRAC_BITS  = 8;

    // Fixed field widths of the ports
    localparam int CMD_W     = 3;
    localparam int FNUM_W    = 4;
    localparam int CAR_W     = 11;
    localparam int TOL_W     = 8;
    localparam int TGT_OUT_W = 4;
    localparam int MAP_OUT_W = 8;

    // Derived internal widths
    localparam int TGT_W      = $clog2(NUM_FLOORS + 1);
    localparam int IDX_W      = $clog2(NUM_FLOORS);
    localparam int WIDE_W     = CAR_W + 2;
    localparam int HALF_FLOOR = 1 << (FRAC_BITS - 1);
    localparam logic [TOL_W-1:0] TOL_RESET = 8'd13;

    typedef logic [CMD_W-1:0]      cmd_t;
    typedef logic [NUM_FLOORS-1:0] floor_map_t;
    typedef logic [TGT_W-1:0]      floor_t;
    typedef logic [WIDE_W-1:0]     wide_t;

    // Command codes
    localparam cmd_t CMD_PANEL_LIGHT = 3'd0;
    localparam cmd_t CMD_UP_CALL     = 3'd1;
    localparam cmd_t CMD_DOWN_CALL   = 3'd2;
    localparam cmd_t CMD_CLEAR_ALL   = 3'd3;
    localparam cmd_t CMD_IDLE_DECIDE = 3'd4;
    localparam cmd_t CMD_MOVE_UP     = 3'd5;
    localparam cmd_t CMD_MOVE_DOWN   = 3'd6;

    // One input item
    typedef struct packed {
        cmd_t              command;
        logic [FNUM_W-1:0] floor_number;
        logic              light_on;
        logic [CAR_W-1:0]  car_level;
    } item_t;

    // Dispatcher state: request maps, target and direction
    typedef struct packed {
        floor_map_t panel;
        floor_map_t up;
        floor_map_t down;
        floor_t     target;
        logic       dir_up;
    } state_t;

    // Lowest lit floor of a map, 0 if none
    function automatic floor_t lowest_set(input floor_map_t m);
        floor_t res;
        res = '0;
        for (int i = NUM_FLOORS - 1; i >= 0; i--) begin
            if (m[i]) res = floor_t'(i + 1);
        end
        return res;
    endfunction

    // Highest lit floor of a map, 0 if none
    function automatic floor_t highest_set(input floor_map_t m);
        floor_t res;
        res = '0;
        for (int i = 0; i < NUM_FLOORS; i++) begin
            if (m[i]) res = floor_t'(i + 1);
        end
        return res;
    endfunction

    // Floors strictly above floor n
    function automatic floor_map_t mask_above(input floor_t n);
        floor_map_t m;
        for (int i = 0; i < NUM_FLOORS; i++) begin
            m[i] = (floor_t'(i) >= n);
        end
        return m;
    endfunction

    // Floors strictly below floor n
    function automatic floor_map_t mask_below(input floor_t n);
        floor_map_t m;
        for (int i = 0; i < NUM_FLOORS; i++) begin
            m[i] = (floor_t'(i + 1) < n);
        end
        return m;
    endfunction

    // Request bit of floor fl, false outside 1..NUM_FLOORS
    function automatic logic lit(input floor_map_t m, input wide_t fl);
        wide_t d;
        d = fl - wide_t'(1);
        if (fl < wide_t'(1) || fl > wide_t'(NUM_FLOORS)) return 1'b0;
        return m[d[IDX_W-1:0]];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/efs_step.sv */
// Next-state logic of the selector: applies one item to the dispatcher state.
// Depends on efs_pkg. Purely combinational; registers live in the top level.
`default_nettype none

module efs_step (
    input  wire efs_pkg::item_t                 item,
    input  wire efs_pkg::state_t                cur,
    input  wire logic [efs_pkg::TOL_W-1:0]      tolerance,
    output efs_pkg::state_t                     nxt
);
    import efs_pkg::*;

    wide_t      pos_w;
    wide_t      frac;
    wide_t      passed;
    wide_t      nx;
    wide_t      nearest_w;
    wide_t      tgt_w;
    wide_t      tol_w;
    wide_t      fnum_w;
    floor_t     nearest;
    floor_t     r_up;
    floor_t     r_down;
    floor_t     pick;
    floor_map_t above;
    floor_map_t below;
    logic       fnum_ok;
    logic [IDX_W-1:0] fidx;
    logic       dir_eff;

    // Position terms
    always_comb
    begin
        pos_w     = wide_t'(item.car_level);
        frac      = wide_t'(item.car_level[FRAC_BITS-1:0]);
        passed    = (pos_w >> FRAC_BITS) + wide_t'(1);
        nx        = passed + wide_t'(1);
        nearest_w = ((pos_w + wide_t'(HALF_FLOOR)) >> FRAC_BITS) + wide_t'(1);
        nearest   = (nearest_w > wide_t'(NUM_FLOORS)) ? floor_t'(NUM_FLOORS)
                                                      : floor_t'(nearest_w);
        tgt_w     = wide_t'(cur.target);
        tol_w     = wide_t'(tolerance);
        fnum_w    = wide_t'(item.floor_number);
        fnum_ok   = (fnum_w >= wide_t'(1)) && (fnum_w <= wide_t'(NUM_FLOORS));
        fidx      = IDX_W'(fnum_w - wide_t'(1));
    end

    // Both scans from the nearest floor, evaluated side by side
    always_comb
    begin
        above = mask_above(nearest);
        below = mask_below(nearest);
        if (nearest >= floor_t'(NUM_FLOORS)) begin
            r_up = '0;
        end else if (lowest_set((cur.panel | cur.up) & above) != '0) begin
            r_up = lowest_set((cur.panel | cur.up) & above);
        end else begin
            r_up = lowest_set(cur.down & above);
        end
        if (nearest <= floor_t'(1)) begin
            r_down = '0;
        end else if (highest_set((cur.panel | cur.down) & below) != '0) begin
            r_down = highest_set((cur.panel | cur.down) & below);
        end else begin
            r_down = highest_set(cur.up & below);
        end
    end

    // Command decode
    always_comb
    begin
        nxt     = cur;
        dir_eff = cur.dir_up;
        pick    = '0;
        case (item.command)
            CMD_PANEL_LIGHT:
            begin
                if (fnum_ok) nxt.panel[fidx] = item.light_on;
            end
            CMD_UP_CALL:
            begin
                if (fnum_ok) nxt.up[fidx] = item.light_on;
            end
            CMD_DOWN_CALL:
            begin
                if (fnum_ok) nxt.down[fidx] = item.light_on;
            end
            CMD_CLEAR_ALL:
            begin
                nxt.panel = '0;
                nxt.up    = '0;
                nxt.down  = '0;
            end
            CMD_IDLE_DECIDE:
            begin
                // ground and top floors force the direction
                if (nearest == floor_t'(1)) dir_eff = 1'b1;
                else if (nearest == floor_t'(NUM_FLOORS)) dir_eff = 1'b0;
                if (dir_eff) begin
                    pick = r_up;
                    if (r_up == '0 && r_down != '0) begin
                        pick    = r_down;
                        dir_eff = 1'b0;
                    end
                end else begin
                    pick = r_down;
                    if (r_down == '0 && r_up != '0) begin
                        pick    = r_up;
                        dir_eff = 1'b1;
                    end
                end
                nxt.target = pick;
                nxt.dir_up = dir_eff;
            end
            CMD_MOVE_UP:
            begin
                // next floor up may be claimed only until half a floor is passed
                if (frac < tol_w && tgt_w == passed) begin
                    nxt.target = cur.target;
                end else if (tgt_w == nx || frac > wide_t'(HALF_FLOOR)
                             || nx > wide_t'(NUM_FLOORS)) begin
                    nxt.target = cur.target;
                end else if (lit(cur.panel, nx) || lit(cur.up, nx)) begin
                    nxt.target = floor_t'(nx);
                end else if (tgt_w < nx && lit(cur.down, nx)) begin
                    nxt.target = floor_t'(nx);
                end
            end
            CMD_MOVE_DOWN:
            begin
                // levelled at the ground floor stops there
                if (frac < tol_w && passed == wide_t'(1)) begin
                    nxt.target = floor_t'(1);
                end else if (tgt_w == passed || frac < wide_t'(HALF_FLOOR)
                             || passed > wide_t'(NUM_FLOORS)) begin
                    nxt.target = cur.target;
                end else if (lit(cur.panel, passed) || lit(cur.down, passed)) begin
                    nxt.target = floor_t'(passed);
                end else if (tgt_w >= passed && lit(cur.up, passed)) begin
                    nxt.target = floor_t'(passed);
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/elevator_target_floor_select.sv */
// Top level of the elevator target floor selector: item register, state/result
// registers and the handshake. Depends on efs_pkg and efs_step.
`default_nettype none

// Takes one item per clock while the output side does not stall and returns one
// result per item, in order. An item is held in an input register until the state
// can advance, then applied to the request maps, target and direction; the updated
// state is the result and stays on the output ports until taken. out_valid is
// registered and rises as the state registers load the result of the item held in
// the input register. The rate is set by the feedback path from the state
// registers through the scan and decode logic. The output side stalling holds one
// item in the input register and then stalls the input. level_tolerance is written
// through cfg_valid/cfg_ready; it is to be written only while the block is idle,
// which the block itself does not enforce; cfg_ready is always high.
module elevator_target_floor_select (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [efs_pkg::TOL_W-1:0]        level_tolerance,
    // input items
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [efs_pkg::CMD_W-1:0]        command,
    input  wire logic [efs_pkg::FNUM_W-1:0]       floor_number,
    input  wire logic                             light_on,
    input  wire logic [efs_pkg::CAR_W-1:0]        car_level,
    // results
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [efs_pkg::TGT_OUT_W-1:0]         target_floor,
    output logic                                  going_up,
    output logic [efs_pkg::MAP_OUT_W-1:0]         panel_requests,
    output logic [efs_pkg::MAP_OUT_W-1:0]         up_calls,
    output logic [efs_pkg::MAP_OUT_W-1:0]         down_calls
);
    import efs_pkg::*;

    item_t             s1_item_reg;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    state_t            state_reg;
    state_t            state_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [TOL_W-1:0]  tol_reg;
    logic              accept;
    logic              advance;

    // Handshake: state moves only when the result slot is free
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        out_valid_next = advance ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
    end

    // Item register
    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_item_reg.command      <= command;
            s1_item_reg.floor_number <= floor_number;
            s1_item_reg.light_on     <= light_on;
            s1_item_reg.car_level    <= car_level;
        end
    end

    // Next-state logic
    efs_step u_step (
        .item      (s1_item_reg),
        .cur       (state_reg),
        .tolerance (tol_reg),
        .nxt       (state_next)
    );

    // Control, state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            state_reg.panel  <= '0;
            state_reg.up     <= '0;
            state_reg.down   <= '0;
            state_reg.target <= '0;
            state_reg.dir_up <= 1'b1;
            tol_reg          <= TOL_RESET;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) state_reg <= state_next;
            if (cfg_valid && cfg_ready) tol_reg <= level_tolerance;
        end
    end

    // State only changes as a result loads, so it doubles as the result register
    assign out_valid      = out_valid_reg;
    assign target_floor   = TGT_OUT_W'(state_reg.target);
    assign going_up       = state_reg.dir_up;
    assign panel_requests = MAP_OUT_W'(state_reg.panel);
    assign up_calls       = MAP_OUT_W'(state_reg.up);
    assign down_calls     = MAP_OUT_W'(state_reg.down);

    // Checks
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty item register");

    a_target_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.target <= floor_t'(NUM_FLOORS))
        else $error("stored target beyond top floor");

    a_advance_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed item gave no result");

    a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_item_reg.command == CMD_CLEAR_ALL) |=>
            (state_reg.panel == '0 && state_reg.up == '0 && state_reg.down == '0))
        else $error("clear all left request bits set");

    a_dir_only_on_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_item_reg.command != CMD_IDLE_DECIDE) |=> $stable(state_reg.dir_up))
        else $error("direction changed outside idle decision");

    a_state_holds_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without a result");

endmodule

`default_nettype wire

/* tb/sv/efs_dispatch_checker.sv */
// Result checker for elevator_target_floor_select: watches the config, item and result
// channels, keeps its own copy of the request maps, target and direction, and compares.
// Depends on efs_pkg for widths, command codes and the floor map type.
`timescale 1ns / 1ps

module efs_dispatch_checker
    import efs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [TOL_W-1:0]     level_tolerance,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [CMD_W-1:0]     command,
    input  logic [FNUM_W-1:0]    floor_number,
    input  logic                 light_on,
    input  logic [CAR_W-1:0]     car_level,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [TGT_OUT_W-1:0] target_floor,
    input  logic                 going_up,
    input  logic [MAP_OUT_W-1:0] panel_requests,
    input  logic [MAP_OUT_W-1:0] up_calls,
    input  logic [MAP_OUT_W-1:0] down_calls,
    output int unsigned          outstanding,
    output int                   mismatches
);

    // Car status as reported after each item
    typedef struct packed {
        logic [TGT_OUT_W-1:0] target;
        logic                 going_up;
        logic [MAP_OUT_W-1:0] panel;
        logic [MAP_OUT_W-1:0] up;
        logic [MAP_OUT_W-1:0] down;
    } car_status_t;

    car_status_t        status_fifo[$];

    // Shadow dispatcher state
    floor_map_t         panel_map;
    floor_map_t         up_map;
    floor_map_t         down_map;
    int                 target_now;
    logic               heading_up;
    logic [TOL_W-1:0]   tolerance;

    function automatic logic lamp_lit(input floor_map_t m, input int fl);
        if (fl < 1 || fl > NUM_FLOORS) return 1'b0;
        return m[fl-1];
    endfunction

    // Set or clear one light; floors outside the building are ignored
    function automatic floor_map_t with_lamp(input floor_map_t m, input int fl, input logic on);
        floor_map_t r;
        r = m;
        if (fl >= 1 && fl <= NUM_FLOORS) r[fl-1] = on;
        return r;
    endfunction

    function automatic int lowest_above(input floor_map_t m, input int n);
        for (int fl = n + 1; fl <= NUM_FLOORS; fl++)
            if (lamp_lit(m, fl)) return fl;
        return 0;
    endfunction

    function automatic int highest_below(input floor_map_t m, input int n);
        for (int fl = n - 1; fl >= 1; fl--)
            if (lamp_lit(m, fl)) return fl;
        return 0;
    endfunction

    // Upward scan: panel or up call first, then a down call above
    function automatic int scan_up(input int n);
        int r;
        if (n >= NUM_FLOORS) return 0;
        r = lowest_above(panel_map | up_map, n);
        if (r != 0) return r;
        return lowest_above(down_map, n);
    endfunction

    // Downward scan: panel or down call first, then an up call below
    function automatic int scan_down(input int n);
        int r;
        if (n <= 1) return 0;
        r = highest_below(panel_map | down_map, n);
        if (r != 0) return r;
        return highest_below(up_map, n);
    endfunction

    // Apply one command to the shadow state and return the status it leaves
    function automatic car_status_t apply_command(input logic [CMD_W-1:0] cmd,
                                                  input logic [FNUM_W-1:0] fnum,
                                                  input logic on,
                                                  input logic [CAR_W-1:0] pos);
        int          p;
        int          frac;
        int          passed;
        int          nearest;
        int          nx;
        int          pick;
        car_status_t s;
        p       = int'(pos);
        frac    = p % (1 << FRAC_BITS);
        passed  = (p >> FRAC_BITS) + 1;
        nearest = ((p + HALF_FLOOR) >> FRAC_BITS) + 1;
        if (nearest > NUM_FLOORS) nearest = NUM_FLOORS;

        case (cmd)
            CMD_PANEL_LIGHT: panel_map = with_lamp(panel_map, int'(fnum), on);
            CMD_UP_CALL:     up_map    = with_lamp(up_map, int'(fnum), on);
            CMD_DOWN_CALL:   down_map  = with_lamp(down_map, int'(fnum), on);
            CMD_CLEAR_ALL:
            begin
                panel_map = '0;
                up_map    = '0;
                down_map  = '0;
            end
            CMD_IDLE_DECIDE:
            begin
                // ground and top floors force the direction
                if (nearest == 1) heading_up = 1'b1;
                else if (nearest == NUM_FLOORS) heading_up = 1'b0;
                if (heading_up)
                begin
                    pick = scan_up(nearest);
                    if (pick == 0)
                    begin
                        pick = scan_down(nearest);
                        if (pick != 0) heading_up = 1'b0;
                    end
                end
                else
                begin
                    pick = scan_down(nearest);
                    if (pick == 0)
                    begin
                        pick = scan_up(nearest);
                        if (pick != 0) heading_up = 1'b1;
                    end
                end
                target_now = pick;
            end
            CMD_MOVE_UP:
            begin
                // next floor may be claimed only before half a floor is passed
                nx = passed + 1;
                if (!((frac < int'(tolerance) && target_now == passed) || target_now == nx
                      || frac > HALF_FLOOR || nx > NUM_FLOORS))
                begin
                    if (lamp_lit(panel_map, nx) || lamp_lit(up_map, nx)) target_now = nx;
                    else if (target_now < nx && lamp_lit(down_map, nx)) target_now = nx;
                end
            end
            CMD_MOVE_DOWN:
            begin
                if (frac < int'(tolerance) && passed == 1) target_now = 1;
                else if (!(target_now == passed || frac < HALF_FLOOR || passed > NUM_FLOORS))
                begin
                    if (lamp_lit(panel_map, passed) || lamp_lit(down_map, passed))
                        target_now = passed;
                    else if (target_now >= passed && lamp_lit(up_map, passed))
                        target_now = passed;
                end
            end
            default: ;
        endcase

        s.target   = TGT_OUT_W'(target_now);
        s.going_up = heading_up;
        s.panel    = MAP_OUT_W'(panel_map);
        s.up       = MAP_OUT_W'(up_map);
        s.down     = MAP_OUT_W'(down_map);
        return s;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Sample all three channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        car_status_t want;
        if (!rst_n)
        begin
            status_fifo.delete();
            panel_map   = '0;
            up_map      = '0;
            down_map    = '0;
            target_now  = 0;
            heading_up  = 1'b1;
            tolerance   = TOL_RESET;
            outstanding = 0;
            mismatches  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready) tolerance = level_tolerance;

            if (out_valid && !out_stall)
            begin
                if (status_fifo.size() == 0)
                begin
                    $error("result with no item outstanding: target_floor %0d", target_floor);
                    mismatches++;
                end
                else
                begin
                    want = status_fifo.pop_front();
                    check_field("target_floor", want.target, target_floor);
                    check_field("going_up", want.going_up, going_up);
                    check_field("panel_requests", want.panel, panel_requests);
                    check_field("up_calls", want.up, up_calls);
                    check_field("down_calls", want.down, down_calls);
                end
            end

            if (in_valid && !in_stall)
                status_fifo.push_back(apply_command(command, floor_number, light_on, car_level));

            outstanding = status_fifo.size();
        end
    end

endmodule

/* tb/sv/tb_elevator_target_floor_select.sv */
// Testbench top for elevator_target_floor_select: clock, reset, directed and random items,
// tolerance writes between phases and the verdict. Depends on efs_pkg and efs_dispatch_checker.
`timescale 1ns / 1ps

module tb_elevator_target_floor_select;
    import efs_pkg::*;

    localparam cmd_t CMD_UNUSED     = 3'd7;
    localparam int   PHASE_ITEMS    = 270;
    localparam int   PHASES         = 6;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [TOL_W-1:0]     level_tolerance;
    logic                 in_valid;
    logic                 in_stall;
    logic [CMD_W-1:0]     command;
    logic [FNUM_W-1:0]    floor_number;
    logic                 light_on;
    logic [CAR_W-1:0]     car_level;
    logic                 out_valid;
    logic                 out_stall;
    logic [TGT_OUT_W-1:0] target_floor;
    logic                 going_up;
    logic [MAP_OUT_W-1:0] panel_requests;
    logic [MAP_OUT_W-1:0] up_calls;
    logic [MAP_OUT_W-1:0] down_calls;

    int unsigned          outstanding;
    int                   fail_count;
    bit                   sender_quiet;
    logic [TOL_W-1:0]     tolerance_plan [PHASES] = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd0, 8'd13};

    elevator_target_floor_select dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .level_tolerance(level_tolerance),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .floor_number   (floor_number),
        .light_on       (light_on),
        .car_level      (car_level),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .target_floor   (target_floor),
        .going_up       (going_up),
        .panel_requests (panel_requests),
        .up_calls       (up_calls),
        .down_calls     (down_calls)
    );

    efs_dispatch_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .level_tolerance(level_tolerance),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .floor_number   (floor_number),
        .light_on       (light_on),
        .car_level      (car_level),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .target_floor   (target_floor),
        .going_up       (going_up),
        .panel_requests (panel_requests),
        .up_calls       (up_calls),
        .down_calls     (down_calls),
        .outstanding    (outstanding),
        .mismatches     (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Result side back-pressure: free runs, short stalls, the odd long one
    initial
    begin : result_stall
        int run;
        int len;
        out_stall = 1'b0;
        forever
        begin
            run = ($urandom_range(0, 99) < 20) ? $urandom_range(40, 150) : $urandom_range(1, 6);
            repeat (run) @(negedge clk);
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
            out_stall <= 1'b1;
            repeat (len) @(negedge clk);
            out_stall <= 1'b0;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input cmd_t c, input logic [FNUM_W-1:0] f, input logic on,
                             input logic [CAR_W-1:0] pos);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (sender_quiet || r < 60) gap = 0;
        else if (r < 92)            gap = $urandom_range(1, 3);
        else                        gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        command      <= c;
        floor_number <= f;
        light_on     <= on;
        car_level    <= pos;
        in_valid     <= 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        while (outstanding != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        in_valid <= 1'b0;
        wait_idle();
        cfg_valid       <= 1'b1;
        level_tolerance <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Positions are often close to a floor, at half a floor or just short of the next
    task automatic send_random_item();
        int                r;
        int                whole;
        int                frac;
        int                p;
        cmd_t              c;
        logic [FNUM_W-1:0] f;
        logic              on;
        r = $urandom_range(0, 99);
        if (r < 16)      c = CMD_PANEL_LIGHT;
        else if (r < 30) c = CMD_UP_CALL;
        else if (r < 44) c = CMD_DOWN_CALL;
        else if (r < 47) c = CMD_CLEAR_ALL;
        else if (r < 67) c = CMD_IDLE_DECIDE;
        else if (r < 82) c = CMD_MOVE_UP;
        else if (r < 98) c = CMD_MOVE_DOWN;
        else             c = CMD_UNUSED;

        f  = ($urandom_range(0, 99) < 88) ? FNUM_W'($urandom_range(1, NUM_FLOORS))
                                           : FNUM_W'($urandom_range(0, 15));
        on = ($urandom_range(0, 99) < 55);

        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            whole = $urandom_range(0, NUM_FLOORS - 1);
            case ($urandom_range(0, 3))
                0:       frac = $urandom_range(0, 20);
                1:       frac = HALF_FLOOR - 2 + $urandom_range(0, 4);
                2:       frac = (1 << FRAC_BITS) - $urandom_range(1, 20);
                default: frac = $urandom_range(0, (1 << FRAC_BITS) - 1);
            endcase
            p = (whole << FRAC_BITS) + frac;
            if (p > 1792 && $urandom_range(0, 9) != 0) p = 1792;
        end
        else if (r < 97) p = $urandom_range(0, 1792);
        else             p = $urandom_range(1793, 2047);

        send_item(c, f, on, CAR_W'(p));
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        level_tolerance = TOL_RESET;
        in_valid        = 1'b0;
        command         = CMD_PANEL_LIGHT;
        floor_number    = '0;
        light_on        = 1'b0;
        car_level       = '0;
        sender_quiet    = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, reset tolerance
        send_item(CMD_IDLE_DECIDE, 4'd0, 1'b0, 11'd0);      // nothing lit
        send_item(CMD_PANEL_LIGHT, 4'd1, 1'b1, 11'd0);
        send_item(CMD_PANEL_LIGHT, 4'd8, 1'b1, 11'd0);
        send_item(CMD_UP_CALL,     4'd4, 1'b1, 11'd0);
        send_item(CMD_DOWN_CALL,   4'd5, 1'b1, 11'd0);
        send_item(CMD_UP_CALL,     4'd8, 1'b1, 11'd0);
        send_item(CMD_DOWN_CALL,   4'd1, 1'b1, 11'd0);
        send_item(CMD_PANEL_LIGHT, 4'd0, 1'b1, 11'd0);      // floor 0 ignored
        send_item(CMD_DOWN_CALL,   4'd15, 1'b1, 11'd2047);  // above the building, ignored
        send_item(CMD_UNUSED,      4'd9, 1'b1, 11'd2047);
        send_item(CMD_IDLE_DECIDE, 4'd0, 1'b0, 11'd868);
        send_item(CMD_IDLE_DECIDE, 4'd0, 1'b0, 11'd1792);   // top forces down
        send_item(CMD_IDLE_DECIDE, 4'd0, 1'b0, 11'd2047);   // car above the top
        send_item(CMD_MOVE_UP,     4'd0, 1'b0, 11'd517);
        send_item(CMD_MOVE_UP,     4'd0, 1'b0, 11'd712);
        send_item(CMD_MOVE_UP,     4'd0, 1'b0, 11'd640);    // exactly half a floor
        send_item(CMD_MOVE_UP,     4'd0, 1'b0, 11'd1792);   // already at the top
        send_item(CMD_MOVE_DOWN,   4'd0, 1'b0, 11'd10);     // level at the ground floor
        send_item(CMD_MOVE_DOWN,   4'd0, 1'b0, 11'd1152);
        send_item(CMD_MOVE_DOWN,   4'd0, 1'b0, 11'd1084);
        send_item(CMD_PANEL_LIGHT, 4'd8, 1'b0, 11'd0);
        send_item(CMD_CLEAR_ALL,   4'd0, 1'b0, 11'd0);
        send_item(CMD_IDLE_DECIDE, 4'd0, 1'b0, 11'd1024);
        send_item(CMD_MOVE_DOWN,   4'd0, 1'b0, 11'd2047);

        // Random phases, one tolerance setting each
        tolerance_plan[4] = TOL_W'($urandom_range(2, 254));
        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_tolerance(tolerance_plan[ph]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 50 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
                send_random_item();
            end
        end

        in_valid <= 1'b0;
        wait_idle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/efs_pkg.sv
hw/rtl/efs_step.sv
hw/rtl/elevator_target_floor_select.sv
tb/sv/efs_dispatch_checker.sv
tb/sv/tb_elevator_target_floor_select.sv
